// File: hw/rtl/trht_pkg.sv
package trht_pkg;

    // Region table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int ADDR_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int HIT_IDX_W   = 4;

    // Command codes carried on tuser
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // Region kinds; code three is stored as given and tested as a rectangle
    localparam logic [1:0] KIND_RECT   = 2'd0;
    localparam logic [1:0] KIND_CIRCLE = 2'd1;
    localparam logic [1:0] KIND_END    = 2'd2;

    // Slave tdata layout, lowest bit first
    localparam int IN_TDATA_W = 56;
    localparam int OUT_TDATA_W = 8;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] p0;   // top edge or centre x
        logic [7:0] p1;   // bottom edge or centre y
        logic [7:0] p2;   // left edge or radius
        logic [7:0] p3;   // right edge
    } entry_t;

    localparam entry_t ENTRY_CLEAR = '{kind: KIND_END, p0: 8'd0, p1: 8'd0, p2: 8'd0, p3: 8'd0};

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_SCAN
    } state_t;

endpackage

// File: hw/rtl/touch_region_hit_test.sv
// Touch region hit test. A write transfer (tuser = 0) stores one region in a 16-entry table
// held in a single synchronous memory; its result (hit 0, index 0) is registered and ready
// in the cycle after. A query transfer (tuser = 1) with touched set scans the table from
// entry 0, one entry per cycle through the memory's one read port, and stops at the first
// region holding the point, at the first end marker or after the last entry: such a query
// reads 1 to 16 entries before the next transfer is taken. An untouched query returns no
// hit without a scan. A rectangle holds the point for left <= x < right and top <= y < bottom,
// with wrap-around edges; a circle for dx*dx + dy*dy < r*r. Each table entry has a valid flag
// cleared by reset, so the table reads as end markers straight out of reset with no clearing
// pass. The result register holds each result until m_tready; while it waits, a new transfer
// is taken only at the edge that also takes the waiting result.
module touch_region_hit_test
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // entry_index[3:0], entry_kind[5:4], shape_p0[13:6], shape_p1[21:14], shape_p2[29:22],
    // shape_p3[37:30], point_x[45:38], point_y[53:46], touched[54], zero[55]
    input  logic [trht_pkg::IN_TDATA_W-1:0]   s_tdata,
    // cmd[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // hit[0], hit_index[4:1], zero[7:5]
    output logic [trht_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import trht_pkg::*;

    // Input field unpacking
    logic [3:0] in_entry_index;
    entry_t     in_entry;
    logic [7:0] in_point_x;
    logic [7:0] in_point_y;
    logic       in_touched;

    assign in_entry_index = s_tdata[3:0];
    assign in_entry.kind  = s_tdata[5:4];
    assign in_entry.p0    = s_tdata[13:6];
    assign in_entry.p1    = s_tdata[21:14];
    assign in_entry.p2    = s_tdata[29:22];
    assign in_entry.p3    = s_tdata[37:30];
    assign in_point_x     = s_tdata[45:38];
    assign in_point_y     = s_tdata[53:46];
    assign in_touched     = s_tdata[54];

    // Registers
    state_t                 state_reg, state_next;
    logic [ADDR_W-1:0]      eval_idx_reg, eval_idx_next;
    logic [7:0]             px_reg, py_reg;
    logic                   out_valid_reg;
    logic                   out_hit_reg;
    logic [HIT_IDX_W-1:0]   out_idx_reg;

    // Table memory, its valid flags and registered read port
    entry_t                 table_mem [TABLE_DEPTH];
    logic [TABLE_DEPTH-1:0] vld_reg;
    entry_t                 rd_data_reg;
    logic                   rd_vld_reg;
    logic [ADDR_W-1:0]      rd_addr;

    logic                   s_xfer;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic                   out_free;
    logic                   load_out;
    logic                   res_hit;
    logic [HIT_IDX_W-1:0]   res_idx;

    assign s_xfer   = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;
    assign wr_en    = s_xfer && (s_tuser == CMD_WRITE) && (int'(in_entry_index) < TABLE_DEPTH);
    assign wr_addr  = ADDR_W'(in_entry_index);

    // Memory: writes only happen while idle, and a scan's first read is issued no earlier
    // than its own accept edge, so a read that a scan uses never overlaps a write to the same entry
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= in_entry;
        end
        rd_data_reg <= table_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    // Entry under test; an unwritten entry reads as an end marker
    entry_t      cur;
    logic        is_end;
    logic        is_last;
    logic        in_x, in_y, in_rect;
    logic [7:0]  dx, dy;
    logic [15:0] dx_sq, dy_sq, r_sq;
    logic [16:0] dist_sq;
    logic        in_circle;
    logic        pt_in_region;
    logic        scan_done;

    assign cur     = rd_vld_reg ? rd_data_reg : ENTRY_CLEAR;
    assign is_end  = (cur.kind == KIND_END);
    assign is_last = (eval_idx_reg == ADDR_W'(TABLE_DEPTH - 1));

    // Rectangle: modular differences on 8 bits match the wide wrap rule
    assign in_x    = (8'(px_reg - cur.p2)) < (8'(cur.p3 - cur.p2));
    assign in_y    = (8'(py_reg - cur.p0)) < (8'(cur.p1 - cur.p0));
    assign in_rect = in_x && in_y;

    // Circle
    assign dx        = (cur.p0 >= px_reg) ? (cur.p0 - px_reg) : (px_reg - cur.p0);
    assign dy        = (cur.p1 >= py_reg) ? (cur.p1 - py_reg) : (py_reg - cur.p1);
    assign dx_sq     = {8'd0, dx} * {8'd0, dx};
    assign dy_sq     = {8'd0, dy} * {8'd0, dy};
    assign r_sq      = {8'd0, cur.p2} * {8'd0, cur.p2};
    assign dist_sq   = {1'b0, dx_sq} + {1'b0, dy_sq};
    assign in_circle = dist_sq < {1'b0, r_sq};

    assign pt_in_region = !is_end && ((cur.kind == KIND_CIRCLE) ? in_circle : in_rect);
    assign scan_done    = is_end || pt_in_region || is_last;

    // State register and scan pointer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            eval_idx_reg <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            eval_idx_reg <= eval_idx_next;
        end
    end

    // Query point capture
    always_ff @(posedge clk)
    begin
        if (s_xfer)
        begin
            px_reg <= in_point_x;
            py_reg <= in_point_y;
        end
    end

    // Next state, read address and result
    always_comb
    begin
        state_next    = state_reg;
        eval_idx_next = eval_idx_reg;
        rd_addr       = '0;
        s_tready      = 1'b0;
        load_out      = 1'b0;
        res_hit       = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                s_tready = out_free;
                if (s_xfer)
                begin
                    if ((s_tuser == CMD_QUERY) && in_touched)
                    begin
                        state_next    = ST_SCAN;
                        eval_idx_next = '0;
                    end
                    else
                    begin
                        load_out = 1'b1;
                    end
                end
            end
            ST_SCAN:
            begin
                if (scan_done)
                begin
                    // keep the current entry on the read port while the result waits
                    rd_addr = eval_idx_reg;
                    if (out_free)
                    begin
                        load_out   = 1'b1;
                        res_hit    = pt_in_region;
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    rd_addr       = ADDR_W'(eval_idx_reg + 1'b1);
                    eval_idx_next = ADDR_W'(eval_idx_reg + 1'b1);
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        res_idx = res_hit ? HIT_IDX_W'(eval_idx_reg) : '0;
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_hit_reg <= res_hit;
            out_idx_reg <= res_idx;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'd0, out_idx_reg, out_hit_reg};

    // A write transfer gives a no-hit result on the next cycle
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && (s_tuser == CMD_WRITE))
        |=> (out_valid_reg && !out_hit_reg && (out_idx_reg == '0)))
    else $error("write transfer did not yield a no-hit result");

    // An untouched query never scans and gives no hit
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && (s_tuser == CMD_QUERY) && !in_touched)
        |=> (state_reg == ST_IDLE && out_valid_reg && !out_hit_reg))
    else $error("untouched query produced a hit or started a scan");

    // A touched query starts the scan at entry zero
    assert property (@(posedge clk) disable iff (!rst_n)
        (s_xfer && (s_tuser == CMD_QUERY) && in_touched)
        |=> (state_reg == ST_SCAN && eval_idx_reg == '0))
    else $error("scan did not start at entry zero");

    // A finished scan with room for its result returns to idle with a result held
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && scan_done && out_free) |=> (state_reg == ST_IDLE && out_valid_reg))
    else $error("finished scan lost its result");

    // A scan never runs past an unwritten entry
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN && !rd_vld_reg) |-> scan_done)
    else $error("scan continued past an end marker");

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import trht_pkg::*;

    // Kind code three has no name in the package; the block treats it as a rectangle
    localparam logic [1:0] KIND_RECT_ALT = 2'd3;

    localparam int RANDOM_ITEMS    = 1930;
    localparam int PHASE_LEN       = 150;
    localparam int HOLD_OFF_CYCLES = 300;
    localparam int TAIL_CYCLES     = 40;
    localparam int QUIET_LIMIT     = 5000;

    // Region table tracker: mirrors the table and queues the expected hit results
    class region_hit_tracker;
        entry_t     regions[TABLE_DEPTH];
        logic [4:0] hit_expected_q[$];   // {hit_index, hit}
        int         mismatches;

        function new();
            foreach (regions[i]) regions[i] = ENTRY_CLEAR;
            mismatches = 0;
        endfunction

        // Containment test; anything but a circle is tested as a rectangle
        function bit region_holds(entry_t e, logic [7:0] x, logic [7:0] y);
            logic [31:0] dx;
            logic [31:0] dy;
            logic [31:0] r;
            if (e.kind == KIND_CIRCLE) begin
                dx = (e.p0 >= x) ? 32'(e.p0) - 32'(x) : 32'(x) - 32'(e.p0);
                dy = (e.p1 >= y) ? 32'(e.p1) - 32'(y) : 32'(y) - 32'(e.p1);
                r  = 32'(e.p2);
                return (dx * dx + dy * dy) < (r * r);
            end
            // wrap differences: left <= x < right, top <= y < bottom
            return ((32'(x) - 32'(e.p2)) < (32'(e.p3) - 32'(e.p2))) &&
                   ((32'(y) - 32'(e.p0)) < (32'(e.p1) - 32'(e.p0)));
        endfunction

        // Accepted input transfer: update the table or scan it
        function void note_transfer(logic cmd, logic [IN_TDATA_W-1:0] data);
            entry_t     e;
            logic [7:0] x;
            logic [7:0] y;
            logic       hit;
            logic [3:0] idx;
            hit = 1'b0;
            idx = 4'd0;
            if (cmd == CMD_WRITE) begin
                e.kind = data[5:4];
                e.p0   = data[13:6];
                e.p1   = data[21:14];
                e.p2   = data[29:22];
                e.p3   = data[37:30];
                if (int'(data[3:0]) < TABLE_DEPTH)
                    regions[data[3:0]] = e;
            end
            else if (data[54]) begin
                x = data[45:38];
                y = data[53:46];
                for (int i = 0; i < TABLE_DEPTH; i++) begin
                    if (regions[i].kind == KIND_END)
                        break;
                    if (region_holds(regions[i], x, y)) begin
                        hit = 1'b1;
                        idx = 4'(i);
                        break;
                    end
                end
            end
            hit_expected_q.push_back({idx, hit});
        endfunction

        task report_mismatch(string msg);
            $display("%0t: mismatch: %s", $time, msg);
            mismatches++;
        endtask

        // Accepted output transfer: compare against the oldest expectation
        task check_result(logic [OUT_TDATA_W-1:0] data);
            logic [4:0] want;
            if (hit_expected_q.size() == 0) begin
                report_mismatch($sformatf("result 0x%h with nothing pending", data));
                return;
            end
            want = hit_expected_q.pop_front();
            if (data[0] !== want[0])
                report_mismatch($sformatf("hit %b, expected %b", data[0], want[0]));
            if (data[4:1] !== want[4:1])
                report_mismatch($sformatf("hit_index %0d, expected %0d",
                                          data[4:1], want[4:1]));
        endtask
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata = '0;
    logic                   s_tuser = CMD_WRITE;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    region_hit_tracker tracker = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    bit hold_req       = 1'b0;

    touch_region_hit_test dut
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Slave tdata packing, lowest field first, one zero pad bit on top
    function automatic logic [IN_TDATA_W-1:0] pack_item(logic [3:0] slot, logic [1:0] kind,
                                                        logic [7:0] p0, logic [7:0] p1,
                                                        logic [7:0] p2, logic [7:0] p3,
                                                        logic [7:0] x, logic [7:0] y,
                                                        logic touched);
        return {1'b0, touched, y, x, p3, p2, p1, p0, kind, slot};
    endfunction

    // One input transfer, with random idle cycles ahead of it
    task automatic send_item(input logic cmd, input logic [IN_TDATA_W-1:0] data);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        tracker.note_transfer(cmd, data);
    endtask

    // Write with random junk in the query fields
    task automatic send_write(input logic [3:0] slot, input logic [1:0] kind,
                              input logic [7:0] p0, input logic [7:0] p1,
                              input logic [7:0] p2, input logic [7:0] p3);
        send_item(CMD_WRITE, pack_item(slot, kind, p0, p1, p2, p3, 8'($urandom()),
                                       8'($urandom()), 1'($urandom())));
    endtask

    // Query with random junk in the entry fields
    task automatic send_query(input logic [7:0] x, input logic [7:0] y, input logic touched);
        send_item(CMD_QUERY, pack_item(4'($urandom()), 2'($urandom()), 8'($urandom()),
                                       8'($urandom()), 8'($urandom()), 8'($urandom()),
                                       x, y, touched));
    endtask

    // Hold the input off until every result is back
    task automatic drain_results();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (tracker.hit_expected_q.size() != 0)
            @(posedge clk);
    endtask

    // Stimulus
    initial
    begin
        logic [7:0] a;
        logic [7:0] b;
        logic [7:0] c;
        logic [7:0] d;
        logic [7:0] x;
        logic [7:0] y;
        logic [1:0] kind;
        entry_t     e;
        int         roll;
        int         lo;
        int         hi;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty table, an untouched and a touched query
        send_query(8'd255, 8'd255, 1'b0);
        send_query(8'd0, 8'd0, 1'b1);
        // full-screen rectangle, far edges exclusive
        send_write(4'd0, KIND_RECT, 8'd0, 8'd255, 8'd0, 8'd255);
        send_query(8'd0, 8'd0, 1'b1);
        send_query(8'd255, 8'd255, 1'b1);
        send_query(8'd254, 8'd254, 1'b0);
        // zero-size rectangle never matches; circle behind it
        send_write(4'd0, KIND_RECT, 8'd10, 8'd10, 8'd10, 8'd10);
        send_write(4'd1, KIND_CIRCLE, 8'd0, 8'd0, 8'd255, 8'd255);
        send_query(8'd10, 8'd10, 1'b1);
        send_query(8'd255, 8'd0, 1'b1);
        // zero-radius circle, then kind three as a rectangle
        send_write(4'd1, KIND_CIRCLE, 8'd255, 8'd255, 8'd0, 8'd0);
        send_write(4'd2, KIND_RECT_ALT, 8'd100, 8'd120, 8'd100, 8'd120);
        send_query(8'd110, 8'd110, 1'b1);
        send_query(8'd120, 8'd110, 1'b1);
        // inverted rectangle: wraps on x
        send_write(4'd3, KIND_RECT, 8'd0, 8'd255, 8'd200, 8'd50);
        send_query(8'd230, 8'd5, 1'b1);
        send_query(8'd20, 8'd5, 1'b1);
        send_query(8'd100, 8'd5, 1'b1);
        send_write(4'd15, KIND_CIRCLE, 8'd128, 8'd128, 8'd40, 8'd255);
        // end marker cuts the scan short
        send_write(4'd2, KIND_END, 8'd255, 8'd255, 8'd255, 8'd255);
        send_query(8'd110, 8'd110, 1'b1);
        send_query(8'd230, 8'd5, 1'b1);
        drain_results();

        // Random part, idling pattern changes every phase
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            case ((n / PHASE_LEN) % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
                default: begin send_idle_pct = 26; recv_stall_pct = 26; end
            endcase
            if (n == 610)
                hold_req = 1'b1;
            if (n == 1200)
                drain_results();

            if ($urandom_range(0, 99) < 40) begin
                roll = $urandom_range(0, 99);
                if (roll < 45)
                    kind = KIND_RECT;
                else if (roll < 85)
                    kind = KIND_CIRCLE;
                else if (roll < 93)
                    kind = KIND_RECT_ALT;
                else
                    kind = KIND_END;
                if (kind == KIND_CIRCLE) begin
                    a = 8'($urandom());
                    b = 8'($urandom());
                    c = ($urandom_range(0, 9) == 0) ? 8'($urandom()) :
                        8'($urandom_range(0, 60));
                    d = 8'($urandom());
                end
                else if ($urandom_range(0, 9) < 7) begin
                    // well-formed rectangle
                    lo = $urandom_range(0, 255);
                    hi = lo + $urandom_range(1, 64);
                    a = 8'(lo);
                    b = 8'((hi > 255) ? 255 : hi);
                    lo = $urandom_range(0, 255);
                    hi = lo + $urandom_range(1, 64);
                    c = 8'(lo);
                    d = 8'((hi > 255) ? 255 : hi);
                end
                else begin
                    a = 8'($urandom());
                    b = 8'($urandom());
                    c = 8'($urandom());
                    d = 8'($urandom());
                end
                send_write(4'($urandom_range(0, 15)), kind, a, b, c, d);
            end
            else begin
                if ($urandom_range(0, 1) == 1) begin
                    // aim near a stored region
                    e = tracker.regions[$urandom_range(0, TABLE_DEPTH - 1)];
                    if (e.kind == KIND_CIRCLE) begin
                        x = 8'(int'(e.p0) + $urandom_range(0, 40) - 20);
                        y = 8'(int'(e.p1) + $urandom_range(0, 40) - 20);
                    end
                    else begin
                        x = 8'(int'(e.p2) + $urandom_range(0, 24) - 4);
                        y = 8'(int'(e.p0) + $urandom_range(0, 24) - 4);
                    end
                end
                else begin
                    x = 8'($urandom());
                    y = 8'($urandom());
                end
                send_query(x, y, 1'($urandom_range(0, 9) != 0));
            end
        end

        // Wind down
        s_tvalid <= 1'b0;
        while (tracker.hit_expected_q.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);
        if (tracker.mismatches == 0)
            $display("[touch_region_hit_test] OK");
        else
            $display("[touch_region_hit_test] ERROR");
        $finish;
    end

    // Result side: check each transfer, drive tready with stalls and one long hold-off
    initial
    begin
        int hold_left;
        hold_left = 0;
        wait (rst_n === 1'b1);
        forever begin
            @(posedge clk);
            if (m_tvalid && m_tready)
                tracker.check_result(m_tdata);
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_OFF_CYCLES;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Watchdog: too long without any transfer ends the run
    initial
    begin
        int quiet;
        quiet = 0;
        wait (rst_n === 1'b1);
        while (quiet < QUIET_LIMIT) begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet = 0;
            else
                quiet++;
        end
        $display("[touch_region_hit_test] ERROR");
        $finish;
    end

endmodule
